// File: rtl/fcvu_pkg.sv
// Package for the fly camera view update unit: field widths, CORDIC angle table,
// angle limits and shared helper functions. No dependencies.
`timescale 1ns / 1ps
package fcvu_pkg;
   localparam int CordicSteps = 16;
   localparam int StepW = $clog2(CordicSteps + 1);
   localparam int YawTurn = 46080;
   localparam int QuarterTurn = 11520;
   localparam int PitchLimit = 11392;
   localparam logic signed [33:0] CordicGain = 34'sd652032874;

   localparam logic [2:0] CSR_POS_X = 3'd0;
   localparam logic [2:0] CSR_POS_Y = 3'd1;
   localparam logic [2:0] CSR_POS_Z = 3'd2;
   localparam logic [2:0] CSR_YAW = 3'd3;
   localparam logic [2:0] CSR_PITCH = 3'd4;

   localparam int ReqW = 1 + 16 + 16 + 32 + 32 + 32;
   localparam int ReqTdataW = ((ReqW - 1 + 7) / 8) * 8;
   localparam int RspW = 8 * 16 + 3 * 32;

   function automatic logic [29:0] atan_lut(input logic [4:0] i);
      case (i)
         5'd0: atan_lut = 30'd377487360;
         5'd1: atan_lut = 30'd222843901;
         5'd2: atan_lut = 30'd117744544;
         5'd3: atan_lut = 30'd59768969;
         5'd4: atan_lut = 30'd30000467;
         5'd5: atan_lut = 30'd15014858;
         5'd6: atan_lut = 30'd7509261;
         5'd7: atan_lut = 30'd3754860;
         5'd8: atan_lut = 30'd1877459;
         5'd9: atan_lut = 30'd938733;
         5'd10: atan_lut = 30'd469367;
         5'd11: atan_lut = 30'd234683;
         5'd12: atan_lut = 30'd117342;
         5'd13: atan_lut = 30'd58671;
         5'd14: atan_lut = 30'd29335;
         5'd15: atan_lut = 30'd14668;
         5'd16: atan_lut = 30'd7334;
         5'd17: atan_lut = 30'd3667;
         5'd18: atan_lut = 30'd1833;
         5'd19: atan_lut = 30'd917;
         5'd20: atan_lut = 30'd458;
         5'd21: atan_lut = 30'd229;
         5'd22: atan_lut = 30'd115;
         5'd23: atan_lut = 30'd57;
         default: atan_lut = 30'd0;
      endcase
   endfunction

   // Saturates a wide signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) sat32 = 32'sh7fffffff;
      else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
   endfunction

   // Q30 CORDIC output to Q14 with rounding and clamp to one.
   function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
      logic signed [33:0] r;
      r = (v + 34'sd32768) >>> 16;
      if (r > 34'sd16384) to_q14 = 16'sd16384;
      else if (r < -34'sd16384) to_q14 = -16'sd16384;
      else to_q14 = r[15:0];
   endfunction
endpackage

// File: rtl/fly_camera_view_update_unit.sv
// Fly camera view update unit: one shared CORDIC stage and one shared multiplier
// under a sequencer. Depends on fcvu_pkg.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | tdata: turn_yaw, turn_pitch, move_right,
//          |           |                      |   move_up, move_forward; tuser: restart
//  rsp     | out       | rsp_tvalid/tready    | tdata: right_x .. fwd_z, shift_x..z
//  csr     | in        | csr_valid/ready      | csr_index, csr_data
//
// An item runs the angle update, two CORDIC passes (yaw, then pitch) of CordicSteps
// rotations each, the multiply steps on the shared multiplier and the hand-off that
// makes the result valid. A new item is accepted only once the current one is through,
// since the one CORDIC stage and one multiplier serve a single item at a time.
// After reset the block spends one pass of the same sequence deriving the start
// forward vector and accepts no item meanwhile. Items wait while a result is
// unread; configuration writes are always taken.
`timescale 1ns / 1ps
module fly_camera_view_update_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // turn_yaw, turn_pitch, move_right, move_up, move_forward (low to high)
   input  logic [fcvu_pkg::ReqTdataW-1:0] req_tdata,
   // restart
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // right_x, right_z, upv_x, upv_y, upv_z, fwd_x, fwd_y, fwd_z, shift_x, shift_y, shift_z
   output logic [fcvu_pkg::RspW-1:0]      rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [2:0]                     csr_index,
   input  logic [31:0]                    csr_data
);
   import fcvu_pkg::*;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_ANGLE, ST_PREP, ST_ROT, ST_POST, ST_MUL, ST_DONE
   } state_type;

   state_type state_ff;
   logic [StepW-1:0] step_ff;
   logic             which_ff;   // 0 yaw, 1 pitch
   logic             init_ff;
   logic [4:0]       mul_ff;

   logic signed [31:0] spx_ff, spy_ff, spz_ff;
   logic signed [16:0] syaw_ff;
   logic signed [14:0] spitch_ff;

   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic signed [16:0] yaw_ff;
   logic signed [14:0] pitch_ff;
   logic signed [15:0] ty_ff, tp_ff;
   logic signed [31:0] mr_ff, mu_ff, mf_ff;

   logic signed [33:0] cx_ff, cy_ff;
   logic signed [31:0] cz_ff;
   logic [1:0]         quad_ff;
   logic signed [15:0] sy_ff, cyv_ff, sp_ff, cp_ff;
   logic signed [15:0] fx_ff, fz_ff, ux_ff, uz_ff;
   logic signed [63:0] acc_ff;
   logic signed [31:0] shx_ff, shy_ff, shz_ff;
   logic               out_valid_ff;

   // Shared multiplier operands chosen by the multiply step.
   logic signed [31:0] ma;
   logic signed [15:0] mb;
   logic signed [47:0] prod;
   logic signed [63:0] rnd_acc;
   logic signed [15:0] rnd16;
   logic signed [15:0] qc, qs, cs_o, sn_o;
   logic signed [17:0] ysum;
   logic signed [16:0] ywrap;
   logic signed [17:0] psum;
   logic signed [14:0] pclamp;
   logic signed [16:0] ang;
   logic signed [17:0] m_ang;
   logic [1:0]         quad;
   logic signed [17:0] rem;
   logic signed [33:0] dx, dy;

   assign rnd_acc = (acc_ff + 64'sd8192) >>> 14;
   assign rnd16   = rnd_acc[15:0];

   always_comb begin
      ma = '0;
      mb = '0;
      case (mul_ff)
         5'd0: begin ma = 32'(cyv_ff); mb = cp_ff; end
         5'd1: begin ma = 32'(sy_ff);  mb = cp_ff; end
         5'd2: begin ma = -32'(cyv_ff); mb = sp_ff; end
         5'd3: begin ma = -32'(sy_ff); mb = sp_ff; end
         5'd4: begin ma = mr_ff; mb = -sy_ff; end
         5'd5: begin ma = mf_ff; mb = fx_ff; end
         5'd6: begin ma = mf_ff; mb = sp_ff; end
         5'd7: begin ma = mr_ff; mb = cyv_ff; end
         5'd8: begin ma = mf_ff; mb = fz_ff; end
         5'd9: begin ma = px_ff; mb = -sy_ff; end
         5'd10: begin ma = pz_ff; mb = cyv_ff; end
         5'd11: begin ma = px_ff; mb = ux_ff; end
         5'd12: begin ma = py_ff; mb = cp_ff; end
         5'd13: begin ma = pz_ff; mb = uz_ff; end
         5'd14: begin ma = px_ff; mb = fx_ff; end
         5'd15: begin ma = py_ff; mb = sp_ff; end
         5'd16: begin ma = pz_ff; mb = fz_ff; end
         default: begin ma = '0; mb = '0; end
      endcase
   end
   assign prod = 48'(ma) * 48'(mb);

   // Angle update for the accepted item.
   always_comb begin
      ysum   = 18'(yaw_ff) + 18'(ty_ff);
      ywrap  = 17'(ysum);
      if (ysum >= 18'sd46080) ywrap = 17'(ysum - 18'sd46080);
      else if (ysum <= -18'sd46080) ywrap = 17'(ysum + 18'sd46080);
      psum   = 18'(pitch_ff) + 18'(tp_ff);
      if (psum > 18'sd11392) pclamp = 15'sd11392;
      else if (psum < -18'sd11392) pclamp = -15'sd11392;
      else pclamp = 15'(psum);
   end

   // Angle reduction to a quadrant and a remainder.
   always_comb begin
      ang   = which_ff ? 17'(pitch_ff) : yaw_ff;
      m_ang = 18'(ang);
      if (m_ang < 0) m_ang = m_ang + 18'sd46080;
      quad = 2'd0;
      rem  = m_ang;
      if (m_ang >= 18'sd34560) begin quad = 2'd3; rem = m_ang - 18'sd34560; end
      else if (m_ang >= 18'sd23040) begin quad = 2'd2; rem = m_ang - 18'sd23040; end
      else if (m_ang >= 18'sd11520) begin quad = 2'd1; rem = m_ang - 18'sd11520; end
   end

   assign dx = cy_ff >>> step_ff;
   assign dy = cx_ff >>> step_ff;

   always_comb begin
      qc = to_q14(cx_ff);
      qs = to_q14(cy_ff);
      case (quad_ff)
         2'd0: begin cs_o = qc;  sn_o = qs;  end
         2'd1: begin cs_o = -qs; sn_o = qc;  end
         2'd2: begin cs_o = -qc; sn_o = -qs; end
         default: begin cs_o = qs; sn_o = -qc; end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {shz_ff, shy_ff, shx_ff, fz_ff, sp_ff, fx_ff,
                        uz_ff, cp_ff, ux_ff, cyv_ff, -sy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         spx_ff <= '0;
         spy_ff <= 32'sd65536;
         spz_ff <= 32'sd163840;
         syaw_ff <= -17'sd11520;
         spitch_ff <= '0;
         px_ff <= '0;
         py_ff <= 32'sd65536;
         pz_ff <= 32'sd163840;
         yaw_ff <= -17'sd11520;
         pitch_ff <= '0;
         ty_ff <= '0;
         tp_ff <= '0;
         mr_ff <= '0;
         mu_ff <= '0;
         mf_ff <= '0;
         state_ff <= ST_INIT;
         init_ff <= 1'b1;
         out_valid_ff <= 1'b0;
         step_ff <= '0;
         which_ff <= 1'b0;
         mul_ff <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_POS_X: spx_ff <= csr_data;
               CSR_POS_Y: spy_ff <= csr_data;
               CSR_POS_Z: spz_ff <= csr_data;
               CSR_YAW:   syaw_ff <= csr_data[16:0];
               CSR_PITCH: spitch_ff <= csr_data[14:0];
               default: ;
            endcase
         end
         if (out_valid_ff && rsp_tready) out_valid_ff <= 1'b0;
         case (state_ff)
            ST_INIT: begin
               state_ff <= ST_ANGLE;
            end
            ST_IDLE: begin
               if (req_tvalid && req_tready) begin
                  ty_ff <= req_tdata[15:0];
                  tp_ff <= req_tdata[31:16];
                  mr_ff <= req_tdata[63:32];
                  mu_ff <= req_tdata[95:64];
                  mf_ff <= req_tdata[127:96];
                  if (req_tuser) begin
                     px_ff <= spx_ff;
                     py_ff <= spy_ff;
                     pz_ff <= spz_ff;
                     // The start yaw spans less than two turns, so one step reduces it.
                     if (syaw_ff >= 17'sd46080) yaw_ff <= syaw_ff - 17'sd46080;
                     else if (syaw_ff <= -17'sd46080) yaw_ff <= syaw_ff + 17'sd46080;
                     else yaw_ff <= syaw_ff;
                     if (spitch_ff > 15'sd11392) pitch_ff <= 15'sd11392;
                     else if (spitch_ff < -15'sd11392) pitch_ff <= -15'sd11392;
                     else pitch_ff <= spitch_ff;
                  end
                  state_ff <= ST_ANGLE;
               end
            end
            ST_ANGLE: begin
               yaw_ff <= ywrap;
               pitch_ff <= pclamp;
               which_ff <= 1'b0;
               state_ff <= ST_PREP;
            end
            ST_PREP: begin
               cx_ff <= CordicGain;
               cy_ff <= '0;
               cz_ff <= 32'(rem) <<< 16;
               quad_ff <= quad;
               step_ff <= '0;
               state_ff <= ST_ROT;
            end
            ST_ROT: begin
               if (cz_ff >= 0) begin
                  cx_ff <= cx_ff - dx;
                  cy_ff <= cy_ff + dy;
                  cz_ff <= cz_ff - 32'(atan_lut(5'(step_ff)));
               end else begin
                  cx_ff <= cx_ff + dx;
                  cy_ff <= cy_ff - dy;
                  cz_ff <= cz_ff + 32'(atan_lut(5'(step_ff)));
               end
               if (step_ff == StepW'(CordicSteps - 1)) state_ff <= ST_POST;
               step_ff <= step_ff + 1'b1;
            end
            ST_POST: begin
               if (!which_ff) begin
                  sy_ff <= sn_o;
                  cyv_ff <= cs_o;
                  which_ff <= 1'b1;
                  state_ff <= ST_PREP;
               end else begin
                  sp_ff <= sn_o;
                  cp_ff <= cs_o;
                  mul_ff <= '0;
                  acc_ff <= '0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               // Steps 0..16 issue products; acc_ff holds the previous step's product or the running sum.
               case (mul_ff)
                  5'd1: begin fx_ff <= rnd16; acc_ff <= 64'(prod); end
                  5'd2: begin fz_ff <= rnd16; acc_ff <= 64'(prod); end
                  5'd3: begin ux_ff <= rnd16; acc_ff <= 64'(prod); end
                  5'd4: begin uz_ff <= rnd16; acc_ff <= 64'(prod); end
                  5'd6: begin
                     px_ff <= sat32(64'(px_ff) + rnd_acc);
                     acc_ff <= 64'(prod);
                  end
                  5'd7: begin
                     py_ff <= sat32(64'(py_ff) + 64'(mu_ff) + rnd_acc);
                     acc_ff <= 64'(prod);
                  end
                  5'd9: begin
                     pz_ff <= sat32(64'(pz_ff) + rnd_acc);
                     acc_ff <= 64'(prod);
                  end
                  5'd11: begin
                     shx_ff <= sat32(-rnd_acc);
                     acc_ff <= 64'(prod);
                  end
                  5'd14: begin
                     shy_ff <= sat32(-rnd_acc);
                     acc_ff <= 64'(prod);
                  end
                  5'd17: begin
                     shz_ff <= sat32(rnd_acc);
                     state_ff <= ST_DONE;
                  end
                  5'd5, 5'd8, 5'd10, 5'd12, 5'd13, 5'd15, 5'd16:
                     acc_ff <= acc_ff + 64'(prod);
                  default: acc_ff <= 64'(prod);
               endcase
               mul_ff <= mul_ff + 1'b1;
            end
            ST_DONE: begin
               if (!init_ff) out_valid_ff <= 1'b1;
               init_ff <= 1'b0;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// File: rtl/fcvu_checker.sv
// Port-level checker for the fly camera view update unit, bound to the top level.
// Depends on fcvu_pkg.
`timescale 1ns / 1ps
module fcvu_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [fcvu_pkg::RspW-1:0] rsp_tdata
);
   import fcvu_pkg::*;

   a_no_ready_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("ready after item");
   a_no_ready_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("ready with result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid) else $error("result too early");
endmodule

bind fly_camera_view_update_unit fcvu_checker u_fcvu_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));

// File: tb/tb_top.sv
// Self-checking testbench for the fly camera view update unit. Drives camera motion
// items and CSR writes, predicts each view result in place, and compares. Uses fcvu_pkg.
`timescale 1ns / 1ps
module tb_top;
   import fcvu_pkg::*;

   typedef struct packed {
      logic        restart;
      logic [15:0] turn_yaw;
      logic [15:0] turn_pitch;
      logic [31:0] move_right;
      logic [31:0] move_up;
      logic [31:0] move_forward;
   } motion_type;

   typedef struct packed {
      logic signed [15:0] rx, rz, ux, uy, uz, fx, fy, fz;
      logic signed [31:0] sx, sy, sz;
   } view_type;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tuser = 0, rsp_tready = 0;
   logic [ReqTdataW-1:0] req_tdata = '0;
   logic rsp_tvalid, req_tready, csr_ready;
   logic [RspW-1:0] rsp_tdata;
   logic csr_valid = 0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   fly_camera_view_update_unit dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Predictor state.
   longint cam_start[5];
   longint cam_x, cam_y, cam_z, cam_yaw, cam_pitch;
   longint atan_tab[16] = '{377487360, 222843901, 117744544, 59768969, 30000467,
      15014858, 7509261, 3754860, 1877459, 938733, 469367, 234683, 117342, 58671,
      29335, 14668};

   motion_type pending_items[$];
   view_type   expected_views[$];
   int      errors = 0;
   int      idle_cycles = 0;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round14(longint v);
      return floor_shift(v + 8192, 14);
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint clip_pitch(longint v);
      if (v > PitchLimit) return PitchLimit;
      if (v < -PitchLimit) return -PitchLimit;
      return v;
   endfunction

   function automatic longint q30_to_q14(longint v);
      longint r;
      r = floor_shift(v + 32768, 16);
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r;
   endfunction

   task automatic angle_sin_cos(input longint a, output longint sn, output longint cs);
      longint m, q, r, x, y, z, dx, dy, c, s;
      m = a % YawTurn;
      if (m < 0) m += YawTurn;
      q = m / QuarterTurn;
      r = m - q * QuarterTurn;
      x = CordicGain;
      y = 0;
      z = r * 65536;
      for (int i = 0; i < CordicSteps; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[i];
         end else begin
            x += dx; y -= dy; z += atan_tab[i];
         end
      end
      c = q30_to_q14(x);
      s = q30_to_q14(y);
      case (q)
         0: begin cs = c;  sn = s;  end
         1: begin cs = -s; sn = c;  end
         2: begin cs = -c; sn = -s; end
         default: begin cs = s; sn = -c; end
      endcase
   endtask

   task automatic reload_camera();
      cam_x = cam_start[CSR_POS_X];
      cam_y = cam_start[CSR_POS_Y];
      cam_z = cam_start[CSR_POS_Z];
      cam_yaw = cam_start[CSR_YAW] % YawTurn;
      cam_pitch = clip_pitch(cam_start[CSR_PITCH]);
   endtask

   task automatic predict_view(input motion_type m);
      longint sy, cy, sp, cp, mr, mu, mf;
      view_type v;
      if (m.restart) reload_camera();
      cam_yaw = (cam_yaw + longint'($signed(m.turn_yaw))) % YawTurn;
      cam_pitch = clip_pitch(cam_pitch + longint'($signed(m.turn_pitch)));
      angle_sin_cos(cam_yaw, sy, cy);
      angle_sin_cos(cam_pitch, sp, cp);
      mr = $signed(m.move_right);
      mu = $signed(m.move_up);
      mf = $signed(m.move_forward);
      v.fx = 16'(round14(cy * cp)); v.fy = 16'(sp); v.fz = 16'(round14(sy * cp));
      v.rx = 16'(-sy); v.rz = 16'(cy);
      v.ux = 16'(round14(-(cy * sp))); v.uy = 16'(cp); v.uz = 16'(round14(-(sy * sp)));
      cam_x = clip32(cam_x + round14(mr * v.rx + mf * v.fx));
      cam_y = clip32(cam_y + mu + round14(mf * v.fy));
      cam_z = clip32(cam_z + round14(mr * v.rz + mf * v.fz));
      v.sx = 32'(clip32(-round14(v.rx * cam_x + v.rz * cam_z)));
      v.sy = 32'(clip32(-round14(v.ux * cam_x + v.uy * cam_y + v.uz * cam_z)));
      v.sz = 32'(clip32(round14(v.fx * cam_x + v.fy * cam_y + v.fz * cam_z)));
      expected_views.push_back(v);
   endtask

   // Driver: bursts of random length with random gaps.
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         // Any item on the bus was accepted; the next one is now at the queue head.
         if (req_tvalid) predict_view(pending_items.pop_front());
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 0;
         end else if (pending_items.size() > 0) begin
            motion_type nx;
            nx = pending_items[0];
            req_tvalid <= 1;
            req_tuser <= nx.restart;
            req_tdata <= {nx.move_forward, nx.move_up, nx.move_right,
                          nx.turn_pitch, nx.turn_yaw};
            if (burst_left == 0) begin
               burst_left <= $urandom_range(12, 1);
               gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(150, 1);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // Receiver stall pattern, with one long hold-off counted here once it is requested.
   int stall_phase = 0;
   int hold_off = 0;
   bit hold_go = 0;
   bit hold_used = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_go && !hold_used) begin
         hold_used <= 1;
         hold_off <= 600;
         rsp_tready <= 0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 0;
      end else begin
         stall_phase <= (stall_phase + 1) % 23;
         rsp_tready <= (stall_phase < 8) ? 1'b1 : ($urandom_range(2, 0) != 0);
      end
   end

   // Monitor and watchdog.
   always @(posedge clock) begin
      view_type got, exp_v;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            {got.sz, got.sy, got.sx, got.fz, got.fy, got.fx, got.uz, got.uy, got.ux,
             got.rz, got.rx} = rsp_tdata;
            if (expected_views.size() == 0) begin
               errors++;
               if (errors <= 10) $display("Unexpected view result %h", rsp_tdata);
            end else begin
               exp_v = expected_views.pop_front();
               if (got !== exp_v) begin
                  errors++;
                  if (errors <= 10)
                     $display("View mismatch: exp r %0d %0d u %0d %0d %0d f %0d %0d %0d ",
                        exp_v.rx, exp_v.rz, exp_v.ux, exp_v.uy, exp_v.uz, exp_v.fx,
                        exp_v.fy, exp_v.fz, "s %0d %0d %0d | got r %0d %0d u %0d %0d %0d ",
                        exp_v.sx, exp_v.sy, exp_v.sz, got.rx, got.rz, got.ux, got.uy,
                        got.uz, "f %0d %0d %0d s %0d %0d %0d", got.fx, got.fy, got.fz,
                        got.sx, got.sy, got.sz);
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 20000) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         CSR_POS_X, CSR_POS_Y, CSR_POS_Z: cam_start[idx] = $signed(val);
         CSR_YAW: cam_start[idx] = $signed(val[16:0]);
         CSR_PITCH: cam_start[idx] = $signed(val[14:0]);
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_tvalid || expected_views.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic motion_type rand_motion(input int mode);
      motion_type m;
      m.restart = ($urandom_range(15, 0) == 0);
      m.turn_yaw = 16'($urandom);
      m.turn_pitch = 16'($urandom);
      m.move_right = $urandom;
      m.move_up = $urandom;
      m.move_forward = $urandom;
      if (mode != 0) begin
         // Small, camera-like motion keeps the position inside range most of the time.
         m.turn_yaw = 16'($signed($urandom_range(2000, 0)) - 1000);
         m.turn_pitch = 16'($signed($urandom_range(1200, 0)) - 600);
         m.move_right = $signed($urandom_range(400000, 0)) - 200000;
         m.move_up = $signed($urandom_range(400000, 0)) - 200000;
         m.move_forward = $signed($urandom_range(400000, 0)) - 200000;
      end
      return m;
   endfunction

   function automatic motion_type mk(logic r, logic [15:0] ty, logic [15:0] tp,
                                  logic [31:0] mr, logic [31:0] mu, logic [31:0] mf);
      motion_type m;
      m = '{r, ty, tp, mr, mu, mf};
      return m;
   endfunction

   task automatic run_phase(input int count, input int mode);
      for (int i = 0; i < count; i++) pending_items.push_back(rand_motion(mode));
   endtask

   initial begin
      cam_start = '{0, 65536, 163840, -QuarterTurn, 0};
      reload_camera();
      repeat (3) @(posedge clock);
      reset <= 0;
      // Directed: zero steps, yaw wrap, pitch clamp both ways, extreme moves.
      pending_items.push_back(mk(0, 0, 0, 0, 0, 0));
      pending_items.push_back(mk(0, 16'h7fff, 0, 0, 0, 0));
      pending_items.push_back(mk(0, 16'h7fff, 16'h7fff, 0, 0, 0));
      pending_items.push_back(mk(0, 16'h8000, 16'h8000, 0, 0, 0));
      pending_items.push_back(mk(0, 16'h8000, 16'h8000, 0, 0, 0));
      pending_items.push_back(mk(0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      pending_items.push_back(mk(0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      pending_items.push_back(mk(0, 16'd5760, 16'd2000, 32'h80000000, 32'h80000000,
                                 32'h80000000));
      pending_items.push_back(mk(0, 16'd11520, 0, 32'h80000000, 32'h80000000,
                                 32'h80000000));
      pending_items.push_back(mk(1, 0, 0, 0, 0, 0));
      pending_items.push_back(mk(1, 16'd11520, 16'hffff, 32'h10000, 32'h10000, 32'h10000));
      wait_drained();
      // Extreme start values; the pitch register is clamped on reload.
      write_csr(CSR_POS_X, 32'h7fffffff);
      write_csr(CSR_POS_Y, 32'h80000000);
      write_csr(CSR_POS_Z, 32'h7fffffff);
      write_csr(CSR_YAW, 32'h0000b3ff);
      write_csr(CSR_PITCH, 32'h00007fff);
      write_csr(3'd7, 32'hffffffff);
      pending_items.push_back(mk(1, 0, 0, 0, 0, 0));
      pending_items.push_back(mk(1, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      wait_drained();
      write_csr(CSR_YAW, 32'h00014c00);
      write_csr(CSR_PITCH, 32'h00004000);
      write_csr(CSR_POS_X, 32'h80000000);
      pending_items.push_back(mk(1, 16'h8000, 0, 0, 0, 0));
      pending_items.push_back(mk(0, 0, 0, 32'h80000000, 0, 32'h7fffffff));
      run_phase(400, 1);
      // Long receiver hold-off while items keep coming.
      hold_go = 1;
      wait_drained();
      for (int p = 0; p < 3; p++) begin
         for (int k = 0; k < 5; k++) write_csr(k[2:0], $urandom);
         run_phase(100, 0);
         run_phase(200, 1);
         wait_drained();
      end
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
